/* rtl/core/tpdh_pkg.sv */
// package for the triple press detector with hold timer
// holds register reset values, ring depth and configuration register indexes
// no dependencies
package tpdh_pkg;

  // field and register widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  // press ring
  localparam int unsigned RingDepth = 3;
  localparam int unsigned SlotW     = $clog2(RingDepth);

  // register reset values
  localparam logic [CountW-1:0] TimerPeriodRst = 16'd62499;
  localparam logic [CountW-1:0] DebounceMinRst = 16'd125;
  localparam logic [TimeW-1:0]  ClickWindowRst = 32'd15625;
  localparam logic [TimeW-1:0]  HoldSpanRst    = 32'd125000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegTimerPeriod = 2'd0,
    RegDebounceMin = 2'd1,
    RegClickWindow = 2'd2,
    RegHoldSpan    = 2'd3
  } cfg_reg_e;

  // item command codes
  localparam logic CmdEdge  = 1'b0;
  localparam logic CmdCheck = 1'b1;

endpackage

/* rtl/core/triple_press_detector_hold_unit.sv */
// An accepted request passes the first stage register and then the result register.
// Throughput: one request per cycle unless the output stalls; the timestamp multiply
// sits in the first stage and the debounce, ring and hold checks in the second stage.
// A request is still taken while a result waits, as long as the first stage is free.
// Reset clears the press ring, edge state and hold start, and loads register defaults.
// top level of the triple press detector with hold timer
// depends on tpdh_pkg
module triple_press_detector_hold_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [tpdh_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tpdh_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [tpdh_pkg::CountW-1:0]     capture_count_i,
  input  logic [tpdh_pkg::TimeW-1:0]      overflow_count_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            in_hold_o,
  output logic                            press_stored_o,
  output logic                            triple_seen_o
);
  import tpdh_pkg::*;

  // configuration registers
  logic [CountW-1:0] timer_period_q;
  logic [CountW-1:0] debounce_min_q;
  logic [TimeW-1:0]  click_window_q;
  logic [TimeW-1:0]  hold_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_period_q <= TimerPeriodRst;
      debounce_min_q <= DebounceMinRst;
      click_window_q <= ClickWindowRst;
      hold_span_q    <= HoldSpanRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegTimerPeriod: timer_period_q <= cfg_wdata_i[CountW-1:0];
        RegDebounceMin: debounce_min_q <= cfg_wdata_i[CountW-1:0];
        RegClickWindow: click_window_q <= cfg_wdata_i[TimeW-1:0];
        RegHoldSpan:    hold_span_q    <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic out_adv;
  logic s1_adv;
  logic in_accept;
  logic s2_fire;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign in_accept  = in_valid_i && s1_adv;
  assign s2_fire    = s1_valid_q && out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage one: timestamp from capture and overflow count, wrapping
  logic [CountW+TimeW-1:0] prod;
  logic [TimeW-1:0]        time_d;
  logic [TimeW-1:0]        time_q;
  logic                    cmd_q;

  assign prod   = timer_period_q * overflow_count_i;
  assign time_d = prod[TimeW-1:0] + {{(TimeW-CountW){1'b0}}, capture_count_i};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      time_q <= time_d;
      cmd_q  <= command_i;
    end
  end

  // detector state
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic             awaiting_q, awaiting_d;
  logic [TimeW-1:0] ring_q [RingDepth];
  logic [TimeW-1:0] ring_d [RingDepth];
  logic [SlotW-1:0] slot_q, slot_d;
  logic [TimeW-1:0] hold_start_q, hold_start_d;

  // next slot after a given slot, wrapping at the ring depth
  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    slot_next = (s == SlotW'(RingDepth - 1)) ? '0 : s + SlotW'(1);
  endfunction

  // stage two: debounce, press capture, triple check and hold compare
  logic [SlotW-1:0] slot_cur;
  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] oldest, middle, newest;
  logic [TimeW-1:0] diff1, diff2;
  logic [TimeW-1:0] hold_end;
  logic             pressed;
  logic             triple;
  logic             hold;
  logic [SlotW-1:0] slot_mid;

  always_comb begin
    // an out of range slot counts as slot zero
    slot_cur     = (slot_q >= SlotW'(RingDepth)) ? '0 : slot_q;
    last_edge_d  = last_edge_q;
    awaiting_d   = awaiting_q;
    ring_d       = ring_q;
    slot_d       = slot_cur;
    pressed      = 1'b0;
    gap          = time_q - last_edge_q;

    // accepted edges alternate between press and release
    if (cmd_q == CmdEdge && gap >= {{(TimeW-CountW){1'b0}}, debounce_min_q}) begin
      last_edge_d = time_q;
      if (awaiting_q) begin
        awaiting_d     = 1'b0;
        ring_d[slot_cur] = time_q;
        slot_d         = slot_next(slot_cur);
        pressed        = 1'b1;
      end else begin
        awaiting_d = 1'b1;
      end
    end

    // ring read oldest first from the write slot
    slot_mid = slot_next(slot_d);
    oldest   = ring_d[slot_d];
    middle   = ring_d[slot_mid];
    newest   = ring_d[slot_next(slot_mid)];
    diff1    = middle - oldest;
    diff2    = newest - middle;
    triple   = (diff1 < click_window_q) && (diff2 < click_window_q);
    hold_start_d = triple ? newest : hold_start_q;

    // hold lasts until hold start plus span, wrapping sum
    hold_end = hold_start_d + hold_span_q;
    hold     = time_q < hold_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q  <= '0;
      awaiting_q   <= 1'b1;
      for (int i = 0; i < RingDepth; i++) begin
        ring_q[i] <= '0;
      end
      slot_q       <= '0;
      hold_start_q <= '0;
    end else if (s2_fire) begin
      last_edge_q  <= last_edge_d;
      awaiting_q   <= awaiting_d;
      ring_q       <= ring_d;
      slot_q       <= slot_d;
      hold_start_q <= hold_start_d;
    end
  end

  // result register
  logic in_hold_q;
  logic press_stored_q;
  logic triple_seen_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      in_hold_q      <= hold;
      press_stored_q <= pressed;
      triple_seen_q  <= triple;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign in_hold_o      = in_hold_q;
  assign press_stored_o = press_stored_q;
  assign triple_seen_o  = triple_seen_q;

endmodule

/* tb/testbench.sv */
// testbench for triple_press_detector_hold_unit: directed and random edge and time-check
// requests against a cycle-free predictor of the press ring, debounce and hold timer
// depends on tpdh_pkg and the unit under test, nothing else
module testbench;
  import tpdh_pkg::*;

  localparam int unsigned StuckLimit = 2000;

  // expected outcome of one request
  typedef struct packed {
    logic in_hold;
    logic press_stored;
    logic triple_seen;
  } hold_outcome_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i      = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic                command_i        = CmdCheck;
  logic [CountW-1:0]   capture_count_i  = '0;
  logic [TimeW-1:0]    overflow_count_i = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic                in_hold_o;
  logic                press_stored_o;
  logic                triple_seen_o;

  // predictor copy of registers and detector state
  logic [CountW-1:0]   period_reg   = TimerPeriodRst;
  logic [CountW-1:0]   debounce_reg = DebounceMinRst;
  logic [TimeW-1:0]    window_reg   = ClickWindowRst;
  logic [TimeW-1:0]    span_reg     = HoldSpanRst;
  logic [TimeW-1:0]    last_edge_q  = '0;
  logic                wait_press_q = 1'b1;
  logic [TimeW-1:0]    press_times [RingDepth] = '{default: '0};
  int unsigned         next_slot    = 0;
  logic [TimeW-1:0]    hold_begin   = '0;

  hold_outcome_t pending_outcomes [$];
  int unsigned   failures     = 0;
  int unsigned   stuck_cycles = 0;
  int unsigned   stall_run    = 0;
  int unsigned   free_run     = 0;
  bit            quiet_mode   = 1'b0;

  triple_press_detector_hold_unit DUT (.*);

  // clock, period 8
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // work out the outcome of one accepted request and queue it
  function automatic void predict_press_outcome(input logic cmd, input logic [CountW-1:0] cap,
                                                input logic [TimeW-1:0] ovf);
    logic [TimeW-1:0] stamp, oldest, middle, newest, hold_end;
    hold_outcome_t    res;
    res   = '0;
    stamp = {16'd0, period_reg} * ovf + {16'd0, cap};
    if (next_slot >= RingDepth) next_slot = 0;
    // edge handling, debounced edges leave the state alone
    if (cmd == CmdEdge) begin
      if (TimeW'(stamp - last_edge_q) >= {16'd0, debounce_reg}) begin
        last_edge_q = stamp;
        if (wait_press_q) begin
          wait_press_q           = 1'b0;
          press_times[next_slot] = stamp;
          next_slot              = (next_slot + 1) % RingDepth;
          res.press_stored       = 1'b1;
        end else begin
          wait_press_q = 1'b1;
        end
      end
    end
    // triple check, oldest entry sits at the write slot
    oldest = press_times[next_slot];
    middle = press_times[(next_slot + 1) % RingDepth];
    newest = press_times[(next_slot + 2) % RingDepth];
    if (TimeW'(middle - oldest) < window_reg && TimeW'(newest - middle) < window_reg) begin
      hold_begin      = newest;
      res.triple_seen = 1'b1;
    end
    hold_end    = hold_begin + span_reg;
    res.in_hold = (stamp < hold_end);
    pending_outcomes.push_back(res);
  endfunction

  // send one request, entered and left at a falling edge
  task automatic send_press_event(input logic cmd, input logic [CountW-1:0] cap,
                                  input logic [TimeW-1:0] ovf);
    int unsigned gap;
    gap = 0;
    if (!quiet_mode && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    capture_count_i  <= cap;
    overflow_count_i <= ovf;
    do @(posedge clk_i); while (in_stall_o);
    predict_press_outcome(cmd, cap, ovf);
    @(negedge clk_i);
  endtask

  // split an absolute tick count into capture and overflow fields
  task automatic send_at_time(input logic cmd, input logic [TimeW-1:0] stamp);
    logic [TimeW-1:0] per;
    per = {16'd0, period_reg};
    send_press_event(cmd, CountW'(stamp % per), stamp / per);
  endtask

  // stop sending and let every expected result come back
  task automatic wait_for_outcomes();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write, only called with the unit idle
  task automatic write_register(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTimerPeriod: period_reg   = data[CountW-1:0];
      RegDebounceMin: debounce_reg = data[CountW-1:0];
      RegClickWindow: window_reg   = data;
      RegHoldSpan:    span_reg     = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // setting drawn from the range, extremes now and then
  function automatic logic [31:0] pick_setting(input logic [31:0] lo, input logic [31:0] hi,
                                              input logic [31:0] usual_hi);
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return $urandom_range(lo, usual_hi);
  endfunction

  // reset defaults: cleared ring, debounce, first press and release
  task automatic test_reset_state();
    send_press_event(CmdCheck, 16'd0, 32'd0);
    send_press_event(CmdEdge, 16'd0, 32'd0);
    send_press_event(CmdEdge, 16'hFFFF, 32'd0);
    send_press_event(CmdEdge, 16'd100, 32'd1);
    send_press_event(CmdCheck, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // three presses inside the window, then the hold boundary
  task automatic test_triple_press();
    wait_for_outcomes();
    write_register(RegTimerPeriod, 32'd1000);
    send_at_time(CmdEdge, 32'd200000);
    send_at_time(CmdEdge, 32'd201000);
    send_at_time(CmdEdge, 32'd205000);
    send_at_time(CmdEdge, 32'd205050);
    send_at_time(CmdEdge, 32'd206000);
    send_at_time(CmdEdge, 32'd210000);
    send_at_time(CmdCheck, 32'd334999);
    send_at_time(CmdCheck, 32'd335000);
  endtask

  // register extremes, zero window, zero debounce and wrapping timestamps
  task automatic test_register_extremes();
    wait_for_outcomes();
    write_register(RegTimerPeriod, 32'd65535);
    write_register(RegDebounceMin, 32'd65535);
    write_register(RegClickWindow, 32'd0);
    write_register(RegHoldSpan, 32'hFFFF_FFFF);
    send_press_event(CmdEdge, 16'hFFFF, 32'hFFFF_FFFF);
    send_press_event(CmdEdge, 16'd0, 32'h8000_0001);
    send_press_event(CmdCheck, 16'hFFFF, 32'h0000_FFFF);
    wait_for_outcomes();
    write_register(RegTimerPeriod, 32'd1);
    write_register(RegDebounceMin, 32'd0);
    write_register(RegClickWindow, 32'hFFFF_FFFF);
    write_register(RegHoldSpan, 32'd0);
    send_press_event(CmdEdge, 16'd0, 32'h0000_1234);
    send_press_event(CmdEdge, 16'd0, 32'h0000_1234);
    send_press_event(CmdEdge, 16'd0, 32'h0000_1234);
    send_press_event(CmdCheck, 16'd0, 32'h0000_1234);
  endtask

  // random phases: mostly press sequences near the timing limits, some raw noise
  task automatic test_random_traffic();
    logic [TimeW-1:0] cursor, delta, win_lim, span_lim;
    logic             cmd;
    cursor = 32'd500000;
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_outcomes();
      write_register(RegTimerPeriod, pick_setting(32'd1, 32'd65535, 32'd65535));
      write_register(RegDebounceMin, pick_setting(32'd0, 32'd65535, 32'd400));
      write_register(RegClickWindow, pick_setting(32'd0, 32'hFFFF_FFFF, 32'd20000));
      write_register(RegHoldSpan, pick_setting(32'd0, 32'hFFFF_FFFF, 32'd300000));
      quiet_mode = (phase == 5);
      win_lim  = (window_reg > 32'd50000) ? 32'd50000 : window_reg;
      span_lim = (span_reg > 32'd300000) ? 32'd300000 : span_reg;
      for (int n = 0; n < 250; n++) begin
        // sender holds off until the pipeline is empty
        if (phase == 2 && n == 125) wait_for_outcomes();
        if ($urandom_range(0, 99) < 12) begin
          send_press_event(1'($urandom_range(0, 1)), CountW'($urandom), $urandom);
        end else begin
          if ($urandom_range(0, 99) == 0) cursor = 32'hFFFF_FFFF - $urandom_range(0, 200000);
          case ($urandom_range(0, 3))
            0:       delta = $urandom_range(0, {16'd0, debounce_reg});
            1:       delta = {16'd0, debounce_reg} + $urandom_range(0, 40);
            2:       delta = $urandom_range(0, 2 * win_lim + 2);
            default: delta = $urandom_range(0, span_lim + 2);
          endcase
          cursor = cursor + delta;
          cmd    = ($urandom_range(0, 4) == 0) ? CmdCheck : CmdEdge;
          send_at_time(cmd, cursor);
        end
      end
    end
  endtask

  // result checker, compares with the oldest expectation
  always @(posedge clk_i) begin
    hold_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = pending_outcomes.pop_front();
        if (in_hold_o !== want.in_hold) begin
          $error("in_hold: expected %0b, got %0b", want.in_hold, in_hold_o);
          failures++;
        end
        if (press_stored_o !== want.press_stored) begin
          $error("press_stored: expected %0b, got %0b", want.press_stored, press_stored_o);
          failures++;
        end
        if (triple_seen_o !== want.triple_seen) begin
          $error("triple_seen: expected %0b, got %0b", want.triple_seen, triple_seen_o);
          failures++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (quiet_mode) begin
      stall_run = 0;
      free_run  = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0 && free_run == 0) begin
        if ($urandom_range(0, 2) == 0) stall_run = $urandom_range(1, 16);
        else free_run = $urandom_range(1, 40);
      end
      if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else begin
        out_stall_i <= 1'b0;
        free_run--;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_triple_press();
    test_register_extremes();
    test_random_traffic();
    wait_for_outcomes();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
